[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk while arst_n is high.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every rising edge of clk while arst_n is high.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/krs_pkg.sv]
// Package with types, constants and the weight table of the kernel smoother.
package krs_pkg;

	localparam int MAX_SAMPLES       = 1024;
	localparam int WEIGHT_TABLE_SIZE = 256;

	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W  = $clog2(WEIGHT_TABLE_SIZE);
	localparam int W_W    = 16;
	localparam int DEN_W  = W_W + ADDR_W;
	localparam int P_W    = 63;
	localparam int DVD_W  = 64;
	localparam int TAB_SQ = WEIGHT_TABLE_SIZE * WEIGHT_TABLE_SIZE;

	localparam logic [30:0]    NORM_SCALE = 31'd1591932205;
	localparam logic [W_W-1:0] W_ONE      = 16'd32768;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic CFG_KERNEL_MODE = 1'b0;
	localparam logic CFG_BANDWIDTH   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

	// One sample as it moves down the row of index cells.
	typedef struct packed {
		logic               vld;
		logic               hit;
		logic               sat;
		logic               pz;
		logic signed [31:0] y;
		logic [P_W-1:0]     r;
		logic [IDX_W-1:0]   q;
	} cell_beat_t;

	typedef logic [WEIGHT_TABLE_SIZE-1:0][W_W-1:0] wtab_t;

	// exp(-t*t/2) in Q1.15 for t = 4*i/SIZE, as a short series raised to the 64th power.
	// The six series terms alternate in sign, each one the previous times b over k.
	function automatic wtab_t build_wtab();
		wtab_t           tab;
		longint unsigned b;
		longint unsigned term;
		longint unsigned sum;
		for (int i = 0; i < WEIGHT_TABLE_SIZE; i++) begin
			b    = ((longint'(i) * longint'(i)) << 28) / TAB_SQ;
			term = 64'h8000_0000;
			sum  = 64'h8000_0000;
			term = (term * b) >> 31;
			sum  = sum - term;
			term = ((term * b) >> 31) >> 1;
			sum  = sum + term;
			term = ((term * b) >> 31) / 64'd3;
			sum  = sum - term;
			term = ((term * b) >> 31) >> 2;
			sum  = sum + term;
			term = ((term * b) >> 31) / 64'd5;
			sum  = sum - term;
			term = ((term * b) >> 31) / 64'd6;
			sum  = sum + term;
			for (int s = 0; s < 6; s++) begin
				sum = (sum * sum) >> 31;
			end
			tab[i] = W_W'((sum + 64'd32768) >> 16);
		end
		return tab;
	endfunction

	localparam wtab_t WTAB = build_wtab();

endpackage

[rtl/krs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module krs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/krs_cell.sv]
// One cell of the index row: develops one quotient bit of the table index.
module krs_cell import krs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [P_W-1:0] p,
	input  cell_beat_t     beat_in,
	output cell_beat_t     beat_out
);

	logic [P_W:0] r2;
	logic         ge;
	logic [P_W:0] r_sub;
	cell_beat_t   beat_d;
	cell_beat_t   beat_q;
	logic         vld_q;

	always_comb begin
		r2       = {beat_in.r, 1'b0};
		ge       = r2 >= {1'b0, p};
		r_sub    = r2 - {1'b0, p};
		beat_d   = beat_in;
		beat_d.r = ge ? r_sub[P_W-1:0] : r2[P_W-1:0];
		beat_d.q = {beat_in.q[IDX_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= beat_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		beat_q <= beat_d;
	end

	always_comb begin
		beat_out     = beat_q;
		beat_out.vld = vld_q;
	end

endmodule

[rtl/krs_div.sv]
// Restoring divider, one quotient bit per cycle.
module krs_div import krs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_DW = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_DW-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DEN_W:0]    sh;
	logic              ge;
	logic [DEN_W:0]    sh_sub;

	always_comb begin
		sh     = {rem_q, quo_q[DVD_W-1]};
		ge     = sh >= {1'b0, divisor};
		sh_sub = sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_DW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_DW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? sh_sub[DEN_W-1:0] : sh[DEN_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/kernel_regression_smoother_core.sv]
// Top level of the Nadaraya-Watson kernel smoother.
// Each request beat carries a command. A load appends (point_x, sample_y) to the sample
// store; loads past MAX_SAMPLES are dropped. A clear empties the store. A query at point_x
// walks every stored sample, one read of the sample RAM per cycle, and returns one response
// beat with the weighted mean of y over the samples inside the kernel window, rounded to
// nearest and saturated, or has_value low when no sample falls in the window. A query
// scans the store, drains the row of IDX_W index cells and the weight, product and
// accumulation stages, runs the bit-serial divider when the weight sum is not zero and
// then loads the output register. Requests are taken only between queries. The sample
// RAM needs no clearing after reset, since only entries below the fill count are read.
// The response sits in an output register, so a new request may be taken while it waits.
// Register 0 selects the kernel (0 box, 1 normal); register 1 is the Q16.16 bandwidth.
// Configuration must be written only while the block is idle; it does not enforce this.
module kernel_regression_smoother_core import krs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] sample_y,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [31:0] smoothed_y,
	output logic               has_value
);

	state_t state_q, state_d;

	logic              kernel_mode_q;
	logic [31:0]       bandwidth_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_q;
	logic signed [31:0] x0_q;
	logic [P_W-1:0]    p_q;
	logic              mode_q;
	logic              rd_vld_s1;
	logic signed [63:0] num_q;
	logic [DEN_W-1:0]  den_q;
	logic              rsp_valid_q;
	logic signed [31:0] rsp_y_q;
	logic              rsp_has_q;

	logic issue;
	logic div_start;
	logic rsp_load;
	logic pipe_busy;
	logic accept;
	logic load_we;

	// Sample store: x in the upper half, y in the lower half.
	logic [63:0] rd_data;
	logic signed [31:0] rd_x;
	logic signed [31:0] rd_y;

	assign accept  = req_valid && req_ready;
	assign load_we = accept && (cmd == CMD_LOAD) && (count_q < CNT_W'(MAX_SAMPLES));

	krs_ram #(
		.WIDTH(64),
		.DEPTH(MAX_SAMPLES)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata({point_x, sample_y}),
		.re   (issue),
		.raddr(scan_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	assign rd_x = rd_data[63:32];
	assign rd_y = rd_data[31:0];

	// Distance and window test on the sample just read.
	logic signed [33:0] diff;
	logic signed [33:0] neg_diff;
	logic [32:0]        abs_d;
	logic [P_W-1:0]     nd;
	logic               box_hit;
	logic               norm_hit;
	cell_beat_t         beat0;

	always_comb begin
		diff     = {{2{rd_x[31]}}, rd_x} - {{2{x0_q[31]}}, x0_q};
		neg_diff = -diff;
		abs_d    = diff[33] ? neg_diff[32:0] : diff[32:0];
		nd       = {abs_d, 30'b0};
		box_hit  = {abs_d, 1'b0} <= {2'b0, bandwidth_q};
		norm_hit = nd <= p_q;
		beat0.vld = rd_vld_s1;
		beat0.hit = mode_q ? norm_hit : box_hit;
		beat0.sat = (nd == p_q);
		beat0.pz  = (p_q == '0);
		beat0.y   = rd_y;
		beat0.r   = nd;
		beat0.q   = '0;
	end

	// Row of index cells: each one develops one bit of floor(nd * SIZE / p).
	cell_beat_t chain [IDX_W+1];
	logic [IDX_W-1:0] chain_vld;

	assign chain[0] = beat0;

	for (genvar k = 0; k < IDX_W; k++) begin : g_cell
		krs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.p       (p_q),
			.beat_in (chain[k]),
			.beat_out(chain[k+1])
		);
		assign chain_vld[k] = chain[k+1].vld;
	end

	// Weight lookup, then product, then accumulation.
	cell_beat_t         tail;
	logic [IDX_W-1:0]   tab_idx;
	logic [W_W-1:0]     w_sel;
	logic               wt_vld_s4;
	logic [W_W-1:0]     w_s4;
	logic signed [31:0] y_s4;
	logic               prod_vld_s5;
	logic [W_W-1:0]     w_s5;
	logic signed [48:0] prod_s5;

	assign tail = chain[IDX_W];

	always_comb begin
		if (tail.pz) begin
			tab_idx = '0;
		end else if (tail.sat) begin
			tab_idx = '1;
		end else begin
			tab_idx = tail.q;
		end
		w_sel = mode_q ? WTAB[tab_idx] : W_ONE;
	end

	assign pipe_busy = rd_vld_s1 || (|chain_vld) || wt_vld_s4 || prod_vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			wt_vld_s4   <= 1'b0;
			prod_vld_s5 <= 1'b0;
		end else begin
			rd_vld_s1   <= issue;
			wt_vld_s4   <= tail.vld && tail.hit;
			prod_vld_s5 <= wt_vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		w_s4    <= w_sel;
		y_s4    <= tail.y;
		w_s5    <= w_s4;
		prod_s5 <= $signed({1'b0, w_s4}) * y_s4;
	end

	// Control state, counters and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			kernel_mode_q <= 1'b0;
			bandwidth_q   <= 32'd65536;
			count_q       <= '0;
			scan_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_KERNEL_MODE: kernel_mode_q <= cfg_data[0];
					CFG_BANDWIDTH:   bandwidth_q   <= cfg_data;
					default:         bandwidth_q   <= bandwidth_q;
				endcase
			end
			if (accept && (cmd == CMD_CLEAR)) begin
				count_q <= '0;
			end else if (load_we) begin
				count_q <= count_q + 1'b1;
			end
			if (accept) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_QUERY)) begin
			x0_q   <= point_x;
			p_q    <= P_W'(bandwidth_q) * P_W'(NORM_SCALE);
			mode_q <= kernel_mode_q;
			num_q  <= '0;
			den_q  <= '0;
		end else if (prod_vld_s5) begin
			num_q <= num_q + {{15{prod_s5[48]}}, prod_s5};
			den_q <= den_q + DEN_W'(w_s5);
		end
	end

	// Rounded division of |num| by den.
	logic [63:0]      mag;
	logic [DVD_W-1:0] dvd;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;
	logic [31:0]      sat_y;

	always_comb begin
		mag = num_q[63] ? 64'(-num_q) : 64'(num_q);
		dvd = mag + 64'(den_q >> 1);
	end

	krs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dvd),
		.divisor (den_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		if (num_q[63]) begin
			if (div_quo > 64'h8000_0000) begin
				sat_y = 32'h8000_0000;
			end else begin
				sat_y = 32'(-div_quo);
			end
		end else begin
			if (div_quo > 64'h7FFF_FFFF) begin
				sat_y = 32'h7FFF_FFFF;
			end else begin
				sat_y = div_quo[31:0];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && (cmd == CMD_QUERY)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_q >= count_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!pipe_busy) state_d = (den_q != '0) ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!rsp_valid_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req_ready = 1'b0;
		issue     = 1'b0;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE:  req_ready = 1'b1;
			ST_SCAN:  issue     = scan_q < count_q;
			ST_DRAIN: div_start = !pipe_busy && (den_q != '0);
			ST_DIV:   rsp_load  = 1'b0;
			ST_OUT:   rsp_load  = !rsp_valid_q;
			default:  req_ready = 1'b0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_has_q <= (den_q != '0);
			rsp_y_q   <= (den_q != '0) ? sat_y : 32'sd0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign smoothed_y = rsp_y_q;
	assign has_value  = rsp_has_q;

endmodule

[rtl/krs_chk.sv]
// Port-level checker for the kernel smoother, bound to the top level.
`include "assert_macros.svh"

module krs_chk import krs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [1:0]         cmd,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [31:0] smoothed_y,
	input logic               has_value
);

	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
	`ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(smoothed_y) && $stable(has_value), "response changed while stalled")
	`ASSERT_IMPLY(a_na_zero, rsp_valid && !has_value, smoothed_y == 32'sd0, "empty window must give zero")
	`ASSERT_NEXT(a_query_busy, req_valid && req_ready && (cmd == CMD_QUERY), !req_ready, "request taken during a query")

endmodule

bind kernel_regression_smoother_core krs_chk u_krs_chk (.*);
